/* hw/rtl/hmm_pkg.sv */
// ----------------------------------------------------------------------------
// hmm_pkg
// Shared types and constants for the handheld memory map decoder.
// ----------------------------------------------------------------------------
package hmm_pkg;

    localparam int VIDEO_BYTES  = 8192;
    localparam int WORK_BYTES   = 8192;
    localparam int HIGH_BYTES   = 128;
    localparam int SPRITE_BYTES = 160;

    localparam int VID_AW  = $clog2(VIDEO_BYTES);
    localparam int WORK_AW = $clog2(WORK_BYTES);
    localparam int HIGH_AW = $clog2(HIGH_BYTES);
    localparam int SPR_AW  = $clog2(SPRITE_BYTES);

    localparam int CLR_DEPTH = (VIDEO_BYTES > WORK_BYTES) ? VIDEO_BYTES : WORK_BYTES;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    localparam logic [15:0] CART_LO_END   = 16'h7FFF;
    localparam logic [15:0] VIDEO_END     = 16'h9FFF;
    localparam logic [15:0] CART_HI_END   = 16'hBFFF;
    localparam logic [15:0] ECHO_END      = 16'hFDFF;
    localparam logic [15:0] SPRITE_END    = 16'hFE9F;
    localparam logic [15:0] UNUSABLE_END  = 16'hFEFF;
    localparam logic [15:0] JOYPAD_ADDR   = 16'hFF00;
    localparam logic [15:0] TIMER_LO      = 16'hFF04;
    localparam logic [15:0] TIMER_HI      = 16'hFF07;
    localparam logic [15:0] FLAGS_ADDR    = 16'hFF0F;
    localparam logic [15:0] IO_END        = 16'hFF7F;
    localparam logic [15:0] HIGH_END      = 16'hFFFE;
    localparam logic [15:0] DMA_ADDR      = 16'hFF46;

    localparam logic [7:0] UNUSABLE_BYTE = 8'hFF;
    localparam logic [2:0] FLAGS_PAD     = 3'b111;
    localparam logic [2:0] IRQ_LINE_MAX  = 3'd4;

    typedef enum logic [3:0] {
        T_CART     = 4'd0,
        T_VIDEO    = 4'd1,
        T_WORK     = 4'd2,
        T_SPRITE   = 4'd3,
        T_UNUSABLE = 4'd4,
        T_JOYPAD   = 4'd5,
        T_TIMER    = 4'd6,
        T_FLAGS    = 4'd7,
        T_OTHER    = 4'd8,
        T_HIGH     = 4'd9,
        T_ENABLE   = 4'd10
    } target_t;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_IRQ   = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } state_t;

    typedef struct packed {
        target_t     target;
        logic        fwd;
        logic [15:0] offset;
        logic        dma_hit;
    } dec_t;

    typedef struct packed {
        logic        en;
        target_t     target;
        logic [15:0] addr;
        logic [7:0]  data;
    } wr_req_t;

endpackage

/* hw/rtl/hmm_decode.sv */
// ----------------------------------------------------------------------------
// hmm_decode
// Address decoder: target region, external forwarding and offset.
// ----------------------------------------------------------------------------
module hmm_decode (
    input  logic [15:0]   address,
    output hmm_pkg::dec_t dec
);

    always_comb
    begin
        dec.fwd     = 1'b0;
        dec.offset  = 16'h0000;
        dec.dma_hit = (address == hmm_pkg::DMA_ADDR);
        priority if (address <= hmm_pkg::CART_LO_END)
            dec.target = hmm_pkg::T_CART;
        else if (address <= hmm_pkg::VIDEO_END)
            dec.target = hmm_pkg::T_VIDEO;
        else if (address <= hmm_pkg::CART_HI_END)
            dec.target = hmm_pkg::T_CART;
        else if (address <= hmm_pkg::ECHO_END)
            dec.target = hmm_pkg::T_WORK;
        else if (address <= hmm_pkg::SPRITE_END)
            dec.target = hmm_pkg::T_SPRITE;
        else if (address <= hmm_pkg::UNUSABLE_END)
            dec.target = hmm_pkg::T_UNUSABLE;
        else if (address == hmm_pkg::JOYPAD_ADDR)
            dec.target = hmm_pkg::T_JOYPAD;
        else if (address >= hmm_pkg::TIMER_LO && address <= hmm_pkg::TIMER_HI)
            dec.target = hmm_pkg::T_TIMER;
        else if (address == hmm_pkg::FLAGS_ADDR)
            dec.target = hmm_pkg::T_FLAGS;
        else if (address <= hmm_pkg::IO_END)
            dec.target = hmm_pkg::T_OTHER;
        else if (address <= hmm_pkg::HIGH_END)
            dec.target = hmm_pkg::T_HIGH;
        else
            dec.target = hmm_pkg::T_ENABLE;

        if (dec.target == hmm_pkg::T_CART)
        begin
            dec.fwd    = 1'b1;
            dec.offset = address;
        end
        else if (dec.target == hmm_pkg::T_JOYPAD || dec.target == hmm_pkg::T_TIMER
                 || dec.target == hmm_pkg::T_OTHER)
        begin
            dec.fwd    = 1'b1;
            dec.offset = {8'h00, address[7:0]};
        end
    end

endmodule

/* hw/rtl/hmm_store.sv */
// ----------------------------------------------------------------------------
// hmm_store
// Video, work, sprite and high RAMs with a registered read port, one write
// port and a clearing port swept after reset.
// ----------------------------------------------------------------------------
module hmm_store (
    input  logic                        clk,
    input  logic                        rd_en,
    input  hmm_pkg::target_t            rd_target,
    input  logic [15:0]                 rd_addr,
    input  hmm_pkg::wr_req_t            wr,
    input  logic                        clr_en,
    input  logic [hmm_pkg::CLR_AW-1:0]  clr_idx,
    output logic [7:0]                  rd_data
);

    logic [7:0] video_mem  [hmm_pkg::VIDEO_BYTES];
    logic [7:0] work_mem   [hmm_pkg::WORK_BYTES];
    logic [7:0] sprite_mem [hmm_pkg::SPRITE_BYTES];
    logic [7:0] high_mem   [hmm_pkg::HIGH_BYTES];

    logic [7:0]       video_q_reg;
    logic [7:0]       work_q_reg;
    logic [7:0]       sprite_q_reg;
    logic [7:0]       high_q_reg;
    hmm_pkg::target_t sel_reg;

    logic [hmm_pkg::VID_AW-1:0]  vid_wa;
    logic [hmm_pkg::WORK_AW-1:0] work_wa;
    logic [hmm_pkg::SPR_AW-1:0]  spr_wa;
    logic [hmm_pkg::HIGH_AW-1:0] high_wa;
    logic [7:0]                  wdata;
    logic                        vid_we;
    logic                        work_we;
    logic                        spr_we;
    logic                        high_we;

    always_comb
    begin
        if (clr_en)
        begin
            vid_wa  = hmm_pkg::VID_AW'(clr_idx);
            work_wa = hmm_pkg::WORK_AW'(clr_idx);
            spr_wa  = hmm_pkg::SPR_AW'(clr_idx);
            high_wa = hmm_pkg::HIGH_AW'(clr_idx);
            wdata   = 8'h00;
            vid_we  = (32'(clr_idx) < hmm_pkg::VIDEO_BYTES);
            work_we = (32'(clr_idx) < hmm_pkg::WORK_BYTES);
            spr_we  = (32'(clr_idx) < hmm_pkg::SPRITE_BYTES);
            high_we = (32'(clr_idx) < hmm_pkg::HIGH_BYTES);
        end
        else
        begin
            vid_wa  = hmm_pkg::VID_AW'(wr.addr[12:0]);
            work_wa = hmm_pkg::WORK_AW'(wr.addr[12:0]);
            spr_wa  = hmm_pkg::SPR_AW'(wr.addr[7:0]);
            high_wa = hmm_pkg::HIGH_AW'(wr.addr[6:0]);
            wdata   = wr.data;
            vid_we  = wr.en && (wr.target == hmm_pkg::T_VIDEO);
            work_we = wr.en && (wr.target == hmm_pkg::T_WORK);
            spr_we  = wr.en && (wr.target == hmm_pkg::T_SPRITE);
            high_we = wr.en && (wr.target == hmm_pkg::T_HIGH);
        end
    end

    always_ff @(posedge clk)
    begin
        if (vid_we)
            video_mem[vid_wa] <= wdata;
        if (rd_en)
            video_q_reg <= video_mem[hmm_pkg::VID_AW'(rd_addr[12:0])];
    end

    always_ff @(posedge clk)
    begin
        if (work_we)
            work_mem[work_wa] <= wdata;
        if (rd_en)
            work_q_reg <= work_mem[hmm_pkg::WORK_AW'(rd_addr[12:0])];
    end

    always_ff @(posedge clk)
    begin
        if (spr_we)
            sprite_mem[spr_wa] <= wdata;
        if (rd_en)
            sprite_q_reg <= sprite_mem[hmm_pkg::SPR_AW'(rd_addr[7:0])];
    end

    always_ff @(posedge clk)
    begin
        if (high_we)
            high_mem[high_wa] <= wdata;
        if (rd_en)
            high_q_reg <= high_mem[hmm_pkg::HIGH_AW'(rd_addr[6:0])];
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            sel_reg <= rd_target;
    end

    always_comb
    begin
        unique case (sel_reg)
            hmm_pkg::T_VIDEO:  rd_data = video_q_reg;
            hmm_pkg::T_WORK:   rd_data = work_q_reg;
            hmm_pkg::T_SPRITE: rd_data = sprite_q_reg;
            hmm_pkg::T_HIGH:   rd_data = high_q_reg;
            default:           rd_data = 8'h00;
        endcase
    end

endmodule

/* hw/rtl/handheld_memory_map_decoder.sv */
// ----------------------------------------------------------------------------
// handheld_memory_map_decoder
// Byte bus decoder for a handheld console memory map with internal RAMs,
// interrupt enable and flag registers.
// ----------------------------------------------------------------------------
// usage
//   slave side: one request beat (tuser = request kind, tdata = address,
//   write byte, interrupt line); master side: one result beat per request
//   (read byte, target, forward flag, external offset, dma trigger)
//   each request is handled in order: the accept edge issues the RAM read,
//   then the busy state, once the output register is free, merges read data,
//   writes back and loads the output register; s_tready stays low while busy,
//   so a new request is taken only after the current one completes
//   after reset a clearing sweep over max(video, work) RAM depth entries (8192
//   with the default sizes) zeroes all RAMs while s_tready stays low
//   a stalled receiver holds the result in the output register; one further
//   request may be accepted and then waits in the busy stage until the
//   output register frees
// ----------------------------------------------------------------------------
module handheld_memory_map_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // req_type
    input  logic [31:0] s_tdata,   // address, write_data, interrupt_line, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // read_data, target, forward_external,
                                   // external_offset, dma_trigger, zero pad
);

    hmm_pkg::state_t  state_reg;
    hmm_pkg::state_t  state_next;
    logic [hmm_pkg::CLR_AW-1:0] clr_cnt_reg;
    logic [hmm_pkg::CLR_AW-1:0] clr_cnt_next;

    hmm_pkg::req_t    req_reg;
    logic [15:0]      addr_reg;
    logic [7:0]       wd_reg;
    logic [2:0]       line_reg;
    hmm_pkg::dec_t    dec_reg;

    logic [7:0]       irq_en_reg;
    logic [7:0]       irq_en_next;
    logic [4:0]       irq_flags_reg;
    logic [4:0]       irq_flags_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [31:0]      out_data_reg;
    logic [31:0]      out_data_next;

    logic             accept;
    logic             complete;
    logic             clr_en;
    hmm_pkg::dec_t    in_dec;
    hmm_pkg::wr_req_t wr;
    logic [7:0]       mem_rd;

    logic [7:0]       res_rd;
    hmm_pkg::target_t res_target;
    logic             res_fwd;
    logic [15:0]      res_offset;
    logic             res_dma;

    hmm_decode u_decode (
        .address (s_tdata[15:0]),
        .dec     (in_dec)
    );

    hmm_store u_store (
        .clk       (clk),
        .rd_en     (accept),
        .rd_target (in_dec.target),
        .rd_addr   (s_tdata[15:0]),
        .wr        (wr),
        .clr_en    (clr_en),
        .clr_idx   (clr_cnt_reg),
        .rd_data   (mem_rd)
    );

    // control
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        s_tready     = 1'b0;
        clr_en       = 1'b0;
        complete     = 1'b0;
        unique case (state_reg)
            hmm_pkg::ST_CLEAR:
            begin
                clr_en       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == hmm_pkg::CLR_AW'(hmm_pkg::CLR_DEPTH - 1))
                    state_next = hmm_pkg::ST_IDLE;
            end
            hmm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = hmm_pkg::ST_BUSY;
            end
            hmm_pkg::ST_BUSY:
            begin
                complete = !out_valid_reg || m_tready;
                if (complete)
                    state_next = hmm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = hmm_pkg::ST_CLEAR;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // result and write-back
    always_comb
    begin
        res_rd         = 8'h00;
        res_target     = dec_reg.target;
        res_fwd        = dec_reg.fwd;
        res_offset     = dec_reg.offset;
        res_dma        = 1'b0;
        irq_en_next    = irq_en_reg;
        irq_flags_next = irq_flags_reg;
        wr.en          = 1'b0;
        wr.target      = dec_reg.target;
        wr.addr        = addr_reg;
        wr.data        = wd_reg;
        unique case (req_reg)
            hmm_pkg::REQ_READ:
            begin
                unique case (dec_reg.target)
                    hmm_pkg::T_VIDEO,
                    hmm_pkg::T_WORK,
                    hmm_pkg::T_SPRITE,
                    hmm_pkg::T_HIGH:     res_rd = mem_rd;
                    hmm_pkg::T_UNUSABLE: res_rd = hmm_pkg::UNUSABLE_BYTE;
                    hmm_pkg::T_FLAGS:    res_rd = {hmm_pkg::FLAGS_PAD, irq_flags_reg};
                    hmm_pkg::T_ENABLE:   res_rd = irq_en_reg;
                    default:             res_rd = 8'h00;
                endcase
            end
            hmm_pkg::REQ_WRITE:
            begin
                wr.en   = complete;
                res_dma = dec_reg.dma_hit;
                if (complete && dec_reg.target == hmm_pkg::T_FLAGS)
                    irq_flags_next = wd_reg[4:0];
                if (complete && dec_reg.target == hmm_pkg::T_ENABLE)
                    irq_en_next = wd_reg;
            end
            hmm_pkg::REQ_IRQ:
            begin
                res_target = hmm_pkg::T_FLAGS;
                res_fwd    = 1'b0;
                res_offset = 16'h0000;
                if (complete && line_reg <= hmm_pkg::IRQ_LINE_MAX)
                    irq_flags_next = irq_flags_reg | (5'b00001 << line_reg);
            end
            default:
            begin
                res_target = hmm_pkg::T_CART;
                res_fwd    = 1'b0;
                res_offset = 16'h0000;
            end
        endcase
        out_data_next = {2'b00, res_dma, res_offset, res_fwd, res_target, res_rd};
        if (complete)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hmm_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            irq_en_reg    <= 8'h00;
            irq_flags_reg <= 5'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            irq_en_reg    <= irq_en_next;
            irq_flags_reg <= irq_flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= hmm_pkg::req_t'(s_tuser);
            addr_reg <= s_tdata[15:0];
            wd_reg   <= s_tdata[23:16];
            line_reg <= s_tdata[26:24];
            dec_reg  <= in_dec;
        end
        if (complete)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hw/rtl/hmm_checker.sv */
// ----------------------------------------------------------------------------
// hmm_checker
// Port-level checks for the handheld memory map decoder.
// ----------------------------------------------------------------------------
module hmm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a request is never accepted while the previous one is busy
    a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted on consecutive cycles");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_fwd_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[12] |-> m_tdata[7:0] == 8'h00)
        else $error("forwarded beat carries read data");

    a_local_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[12] |-> m_tdata[28:13] == 16'h0000)
        else $error("internal beat carries external offset");

    a_dma_is_io: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[29] |-> m_tdata[11:8] == hmm_pkg::T_OTHER && m_tdata[12])
        else $error("dma trigger outside io space");

endmodule

bind handheld_memory_map_decoder hmm_checker u_hmm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/tb_handheld_memory_map_decoder.sv */
// ----------------------------------------------------------------------------
// tb_handheld_memory_map_decoder
// Self-checking bench for the memory map decoder. Bus requests are queued,
// sent in random bursts and mirrored by a behavioural copy of the map and
// its stores; each result beat is compared field by field with the oldest
// predicted outcome while the receiver stalls on its own random pattern.
// ----------------------------------------------------------------------------
module tb_handheld_memory_map_decoder;

    import hmm_pkg::*;

    typedef struct {
        req_t        kind;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [2:0]  line;
        bit          hold;
    } bus_req_t;

    typedef struct {
        logic [7:0]  read_data;
        logic [3:0]  target;
        logic        fwd;
        logic [15:0] offset;
        logic        dma;
    } outcome_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser  = '0;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    bus_req_t    pending_q[$];
    outcome_t    outcome_q[$];
    logic [15:0] written_addrs[$];
    bus_req_t    cur_beat;
    int          errors = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          ready_left = 0;
    int          ready_mode = 0;

    logic [7:0]  vram_copy [VIDEO_BYTES];
    logic [7:0]  wram_copy [WORK_BYTES];
    logic [7:0]  hram_copy [HIGH_BYTES];
    logic [7:0]  oam_copy  [SPRITE_BYTES];
    logic [7:0]  ie_copy;
    logic [4:0]  if_copy;

    handheld_memory_map_decoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),   // req_type
        .s_tdata  (s_tdata),   // address, write_data, interrupt_line, zero pad
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // read_data, target, forward_external,
                               // external_offset, dma_trigger, zero pad
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // decode one request against the map and update the mirrored stores
    function automatic outcome_t apply_request(bus_req_t r);
        outcome_t o;
        target_t  t;
        int       idx;
        o = '{default: '0};
        if (r.kind == REQ_IRQ)
        begin
            if (r.line <= IRQ_LINE_MAX)
                if_copy[r.line] = 1'b1;
            o.target = T_FLAGS;
            return o;
        end
        if (r.kind == REQ_NONE)
            return o;

        if (r.addr <= CART_LO_END)                          t = T_CART;
        else if (r.addr <= VIDEO_END)                       t = T_VIDEO;
        else if (r.addr <= CART_HI_END)                     t = T_CART;
        else if (r.addr <= ECHO_END)                        t = T_WORK;
        else if (r.addr <= SPRITE_END)                      t = T_SPRITE;
        else if (r.addr <= UNUSABLE_END)                    t = T_UNUSABLE;
        else if (r.addr == JOYPAD_ADDR)                     t = T_JOYPAD;
        else if (r.addr >= TIMER_LO && r.addr <= TIMER_HI)  t = T_TIMER;
        else if (r.addr == FLAGS_ADDR)                      t = T_FLAGS;
        else if (r.addr <= IO_END)                          t = T_OTHER;
        else if (r.addr <= HIGH_END)                        t = T_HIGH;
        else                                                t = T_ENABLE;

        o.target = t;
        if (t == T_CART)
        begin
            o.fwd    = 1'b1;
            o.offset = r.addr;
        end
        else if (t == T_JOYPAD || t == T_TIMER || t == T_OTHER)
        begin
            o.fwd    = 1'b1;
            o.offset = r.addr - JOYPAD_ADDR;
        end

        case (t)
            T_VIDEO:  idx = (int'(r.addr) - 'h8000) % VIDEO_BYTES;
            T_WORK:   idx = (int'(r.addr) & 'h1FFF) % WORK_BYTES;
            T_SPRITE: idx = (int'(r.addr) - 'hFE00) % SPRITE_BYTES;
            T_HIGH:   idx = (int'(r.addr) - 'hFF80) % HIGH_BYTES;
            default:  idx = 0;
        endcase

        if (r.kind == REQ_READ)
        begin
            case (t)
                T_VIDEO:    o.read_data = vram_copy[idx];
                T_WORK:     o.read_data = wram_copy[idx];
                T_SPRITE:   o.read_data = oam_copy[idx];
                T_UNUSABLE: o.read_data = UNUSABLE_BYTE;
                T_FLAGS:    o.read_data = {FLAGS_PAD, if_copy};
                T_HIGH:     o.read_data = hram_copy[idx];
                T_ENABLE:   o.read_data = ie_copy;
                default:    o.read_data = '0;
            endcase
        end
        else
        begin
            case (t)
                T_VIDEO:  vram_copy[idx] = r.wdata;
                T_WORK:   wram_copy[idx] = r.wdata;
                T_SPRITE: oam_copy[idx]  = r.wdata;
                T_FLAGS:  if_copy        = r.wdata[4:0];
                T_HIGH:   hram_copy[idx] = r.wdata;
                T_ENABLE: ie_copy        = r.wdata;
                T_OTHER:  o.dma          = (r.addr == DMA_ADDR);
                default:  ;
            endcase
        end
        return o;
    endfunction

    task automatic queue_req(req_t kind, logic [15:0] addr, logic [7:0] wdata,
                             logic [2:0] line, bit hold);
        bus_req_t r;
        r.kind  = kind;
        r.addr  = addr;
        r.wdata = wdata;
        r.line  = line;
        r.hold  = hold;
        pending_q.push_back(r);
    endtask

    function automatic logic [15:0] pick_addr();
        logic [15:0] a;
        case ($urandom_range(0, 9))
            0:       a = $urandom_range(0, 1) ? 16'($urandom_range(0, 'h7FFF))
                                              : 16'($urandom_range('hA000, 'hBFFF));
            1:       a = 16'($urandom_range('h8000, 'h9FFF));
            2:       a = 16'($urandom_range('hC000, 'hDFFF));
            3:       a = 16'($urandom_range('hE000, 'hFDFF));
            4:       a = 16'($urandom_range('hFE00, 'hFE9F));
            5:       a = 16'($urandom_range('hFEA0, 'hFEFF));
            6:
            begin
                case ($urandom_range(0, 7))
                    0:       a = JOYPAD_ADDR;
                    1:       a = 16'($urandom_range(TIMER_LO, TIMER_HI));
                    2:       a = FLAGS_ADDR;
                    3:       a = DMA_ADDR;
                    default: a = 16'($urandom_range('hFF00, 'hFF7F));
                endcase
            end
            7:       a = 16'($urandom_range('hFF80, 'hFFFE));
            8:       a = 16'hFFFF;
            default: a = 16'($urandom);
        endcase
        return a;
    endfunction

    // driver: bursts of beats separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tuser    <= '0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                outcome_q.push_back(apply_request(cur_beat));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_q.size() != 0 &&
                         !(pending_q[0].hold && outcome_q.size() != 0))
                begin
                    cur_beat = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_beat.kind;
                    s_tdata  <= {5'b0, cur_beat.line, cur_beat.wdata, cur_beat.addr};
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: receiver stall pattern and result checks
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_left <= 0;
            ready_mode <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result beat with no request outstanding: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    outcome_t e;
                    e = outcome_q.pop_front();
                    if (m_tdata[7:0] !== e.read_data)
                    begin
                        $error("read_data: expected %h, got %h", e.read_data, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[11:8] !== e.target)
                    begin
                        $error("target: expected %0d, got %0d", e.target, m_tdata[11:8]);
                        errors++;
                    end
                    if (m_tdata[12] !== e.fwd)
                    begin
                        $error("forward_external: expected %b, got %b", e.fwd, m_tdata[12]);
                        errors++;
                    end
                    if (m_tdata[28:13] !== e.offset)
                    begin
                        $error("external_offset: expected %h, got %h",
                               e.offset, m_tdata[28:13]);
                        errors++;
                    end
                    if (m_tdata[29] !== e.dma)
                    begin
                        $error("dma_trigger: expected %b, got %b", e.dma, m_tdata[29]);
                        errors++;
                    end
                end
            end
            if (ready_left == 0)
            begin
                ready_mode <= $urandom_range(0, 2);
                ready_left <= $urandom_range(1, 60);
            end
            else
                ready_left <= ready_left - 1;
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        bus_req_t r;
        int       sel;
        for (int i = 0; i < VIDEO_BYTES; i++)  vram_copy[i] = '0;
        for (int i = 0; i < WORK_BYTES; i++)   wram_copy[i] = '0;
        for (int i = 0; i < HIGH_BYTES; i++)   hram_copy[i] = '0;
        for (int i = 0; i < SPRITE_BYTES; i++) oam_copy[i]  = '0;
        ie_copy = '0;
        if_copy = '0;

        // directed: map edges, echo mirror, flag padding, dma, unused kind
        queue_req(REQ_READ,  16'h0000, 8'h00, 3'd0, 1'b0);
        queue_req(REQ_WRITE, 16'h7FFF, 8'hFF, 3'd0, 1'b0);
        queue_req(REQ_READ,  16'hBFFF, 8'h00, 3'd0, 1'b0);
        queue_req(REQ_WRITE, 16'h8000, 8'hA5, 3'd0, 1'b0);
        queue_req(REQ_WRITE, 16'h9FFF, 8'h5A, 3'd0, 1'b0);
        queue_req(REQ_READ,  16'h9FFF, 8'h00, 3'd0, 1'b0);
        queue_req(REQ_WRITE, 16'hC000, 8'h3C, 3'd0, 1'b0);
        queue_req(REQ_READ,  16'hE000, 8'h00, 3'd0, 1'b0);
        queue_req(REQ_WRITE, 16'hFDFF, 8'hC3, 3'd0, 1'b0);
        queue_req(REQ_READ,  16'hDDFF, 8'h00, 3'd0, 1'b0);
        queue_req(REQ_WRITE, 16'hFE9F, 8'h81, 3'd0, 1'b0);
        queue_req(REQ_READ,  16'hFE9F, 8'h00, 3'd0, 1'b0);
        queue_req(REQ_WRITE, 16'hFEA0, 8'h12, 3'd0, 1'b0);
        queue_req(REQ_READ,  16'hFEFF, 8'h00, 3'd0, 1'b0);
        queue_req(REQ_READ,  16'hFF00, 8'h00, 3'd0, 1'b0);
        queue_req(REQ_WRITE, 16'hFF07, 8'h44, 3'd0, 1'b0);
        queue_req(REQ_IRQ,   16'h0000, 8'h00, 3'd0, 1'b0);
        queue_req(REQ_IRQ,   16'h0000, 8'h00, 3'd4, 1'b0);
        queue_req(REQ_IRQ,   16'hFFFF, 8'hFF, 3'd7, 1'b0);
        queue_req(REQ_READ,  16'hFF0F, 8'h00, 3'd0, 1'b0);
        queue_req(REQ_WRITE, 16'hFF0F, 8'hFF, 3'd0, 1'b0);
        queue_req(REQ_READ,  16'hFF0F, 8'h00, 3'd0, 1'b0);
        queue_req(REQ_WRITE, 16'hFF46, 8'hC0, 3'd0, 1'b0);
        queue_req(REQ_READ,  16'hFF46, 8'h00, 3'd0, 1'b0);
        queue_req(REQ_WRITE, 16'hFFFE, 8'h77, 3'd0, 1'b0);
        queue_req(REQ_WRITE, 16'hFFFF, 8'hFF, 3'd0, 1'b0);
        queue_req(REQ_READ,  16'hFFFF, 8'h00, 3'd0, 1'b0);
        queue_req(REQ_NONE,  16'hFFFF, 8'hFF, 3'd7, 1'b0);

        for (int n = 0; n < 1780; n++)
        begin
            sel     = $urandom_range(0, 99);
            r.hold  = (n % 400 == 0);
            r.wdata = $urandom;
            r.line  = $urandom_range(0, 7);
            r.addr  = pick_addr();
            if (sel < 40)
            begin
                r.kind = REQ_READ;
                if (written_addrs.size() != 0 && $urandom_range(0, 1))
                    r.addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
            end
            else if (sel < 80)
            begin
                r.kind = REQ_WRITE;
                written_addrs.push_back(r.addr);
                if (written_addrs.size() > 64)
                    void'(written_addrs.pop_front());
            end
            else if (sel < 95)
                r.kind = REQ_IRQ;
            else
                r.kind = REQ_NONE;
            pending_q.push_back(r);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid || outcome_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* handheld_memory_map_decoder.f */
hw/rtl/hmm_pkg.sv
hw/rtl/hmm_decode.sv
hw/rtl/hmm_store.sv
hw/rtl/handheld_memory_map_decoder.sv
hw/rtl/hmm_checker.sv
tb/sv/tb_handheld_memory_map_decoder.sv
